/* src/lsbp_pkg.sv */
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types and constants for the LSB-first bit packer: the input and
// result beat layouts, the input mode codes and the internal command format.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CodeWidth = 32;
  localparam int unsigned LenWidth  = 6;
  localparam int unsigned CntWidth  = 32;

  // Mode codes carried by an input beat.
  typedef enum logic [1:0] {
    ModeAppend  = 2'd0,
    ModeClose   = 2'd1,
    ModeRestart = 2'd2
  } lsbp_mode_e;

  // Commands that the front end hands to the back end.
  typedef enum logic [1:0] {
    OpAppend  = 2'd0,
    OpClose   = 2'd1,
    OpRestart = 2'd2
  } lsbp_op_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CodeWidth-1:0] code_value;
    logic [LenWidth-1:0]  code_length;
  } lsbp_in_t;

  typedef struct packed {
    logic [ByteBits-1:0]  out_byte;
    logic                 has_byte;
    logic [CntWidth-1:0]  byte_total;
    logic                 last;
  } lsbp_out_t;

  typedef struct packed {
    lsbp_op_e             op;
    logic [CodeWidth-1:0] code;
    logic [LenWidth-1:0]  len;
  } lsbp_cmd_t;

endpackage

/* src/lsbp_front.sv */
// ----------------------------------------------------------------------------
// lsbp_front
// Decodes input beats into commands: clamps the code length, clears the code
// bits above it and drops beats that cannot change anything.
// ----------------------------------------------------------------------------
module lsbp_front
  import lsbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  lsbp_in_t  in_data_i,
  output logic      cmd_valid_o,
  output lsbp_cmd_t cmd_o
);

  localparam int unsigned Limit = (MAX_CODE_BITS < CodeWidth) ? MAX_CODE_BITS : CodeWidth;
  localparam logic [LenWidth-1:0] LenLimit = LenWidth'(Limit);

  logic [LenWidth-1:0]  len_clamped;
  logic [CodeWidth-1:0] code_mask;

  // Saturate the length and build the mask of valid code bits.
  always_comb begin
    len_clamped = (in_data_i.code_length > LenLimit) ? LenLimit : in_data_i.code_length;
    code_mask   = ~({CodeWidth{1'b1}} << len_clamped);
  end

  // Classify the beat.
  always_comb begin
    cmd_o.code  = in_data_i.code_value & code_mask;
    cmd_o.len   = len_clamped;
    cmd_o.op    = OpAppend;
    cmd_valid_o = 1'b0;
    unique case (in_data_i.mode)
      ModeAppend: begin
        cmd_o.op    = OpAppend;
        cmd_valid_o = (len_clamped != '0);
      end
      ModeClose: begin
        cmd_o.op    = OpClose;
        cmd_valid_o = 1'b1;
      end
      ModeRestart: begin
        cmd_o.op    = OpRestart;
        cmd_valid_o = 1'b1;
      end
      default: begin
        // The unused mode has no effect at all.
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/lsbp_queue.sv */
// ----------------------------------------------------------------------------
// lsbp_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lsbp_queue
  import lsbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lsbp_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      pop_valid_o,
  output lsbp_cmd_t pop_cmd_o
);

  lsbp_cmd_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o      = (fill_q == 2'd2);
  assign pop_valid_o = (fill_q != 2'd0);
  assign pop_cmd_o   = entry_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/lsbp_back.sv */
// ----------------------------------------------------------------------------
// lsbp_back
// Carries out commands: merges codes into the pending bits, emits one full
// byte per cycle into the output register while it is free and keeps the byte count.
// ----------------------------------------------------------------------------
module lsbp_back
  import lsbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  lsbp_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lsbp_out_t out_data_o
);

  localparam int unsigned AccWidth   = CodeWidth + ByteBits - 1;
  localparam int unsigned TotalWidth = $clog2(AccWidth + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } lsbp_state_e;

  lsbp_state_e           state_q, state_d;
  logic [ByteBits-1:0]   pend_bits_q, pend_bits_d;
  logic [2:0]            pend_cnt_q, pend_cnt_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [AccWidth-1:0]   acc_q, acc_d;
  logic [TotalWidth-1:0] total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  lsbp_out_t             out_q, out_d;

  logic                  out_free;
  logic [CntWidth-1:0]   count_inc;
  logic [AccWidth-1:0]   merged;
  logic [TotalWidth-1:0] merged_total;
  logic [TotalWidth-1:0] total_left;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Saturating byte count and the merge of a new code behind the pending bits.
  always_comb begin
    count_inc    = (count_q == '1) ? count_q : count_q + 1'b1;
    merged       = AccWidth'(pend_bits_q) | (AccWidth'(cmd_i.code) << pend_cnt_q);
    merged_total = TotalWidth'(pend_cnt_q) + TotalWidth'(cmd_i.len);
    total_left   = total_q - TotalWidth'(ByteBits);
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    count_d     = count_q;
    acc_d       = acc_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OpAppend: begin
              cmd_pop_o = 1'b1;
              if (merged_total >= TotalWidth'(ByteBits)) begin
                acc_d   = merged;
                total_d = merged_total;
                state_d = StEmit;
              end else begin
                pend_bits_d = merged[ByteBits-1:0];
                pend_cnt_d  = merged_total[2:0];
              end
            end
            OpClose: begin
              if (out_free) begin
                cmd_pop_o      = 1'b1;
                out_valid_d    = 1'b1;
                out_d.last     = 1'b1;
                out_d.out_byte = pend_bits_q;
                out_d.has_byte = (pend_cnt_q != 3'd0);
                if (pend_cnt_q != 3'd0) begin
                  count_d          = count_inc;
                  out_d.byte_total = count_inc;
                end else begin
                  out_d.byte_total = count_q;
                end
                pend_bits_d = '0;
                pend_cnt_d  = '0;
              end
            end
            OpRestart: begin
              cmd_pop_o   = 1'b1;
              pend_bits_d = '0;
              pend_cnt_d  = '0;
              count_d     = '0;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      StEmit: begin
        // One full byte leaves per cycle while the output slot is free.
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.out_byte   = acc_q[ByteBits-1:0];
          out_d.has_byte   = 1'b1;
          out_d.byte_total = count_inc;
          out_d.last       = (total_left < TotalWidth'(ByteBits));
          count_d          = count_inc;
          acc_d            = acc_q >> ByteBits;
          total_d          = total_left;
          if (total_left < TotalWidth'(ByteBits)) begin
            pend_bits_d = acc_q[2*ByteBits-1:ByteBits];
            pend_cnt_d  = total_left[2:0];
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working accumulator and output payload need no reset.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    total_q <= total_d;
    out_q   <= out_d;
  end

endmodule

/* src/lsb_first_bit_packer.sv */
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-length codes into a byte stream, least significant bit
// first, and streams out each byte as it fills up.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat
//   in       input      in_valid_i/in_stall_o  lsbp_in_t  (mode, code, length)
//   out      output     out_valid_o/out_stall_i lsbp_out_t (byte, has, total, last)
//
// An append beat is merged into the pending bits in the back end, which then
// emits each full byte it completes in turn before it takes the next command;
// close and restart are carried out from the idle state.
// Reset is asynchronous and active low and clears the pending bits and the
// byte count. A two-entry command queue lets the input keep taking beats
// while the output is stalled; the output register holds one result.
//
module lsb_first_bit_packer
  import lsbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lsbp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output lsbp_out_t out_data_o
);

  logic      front_valid;
  lsbp_cmd_t front_cmd;
  logic      queue_full;
  logic      queue_valid;
  lsbp_cmd_t queue_cmd;
  logic      queue_pop;

  assign in_stall_o = queue_full;

  // Decode input beats.
  lsbp_front #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_front (
    .in_data_i  (in_data_i),
    .cmd_valid_o(front_valid),
    .cmd_o      (front_cmd)
  );

  // Command queue between the two halves.
  lsbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !queue_full && front_valid),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .pop_valid_o(queue_valid),
    .pop_cmd_o  (queue_cmd)
  );

  // Byte emission and state.
  lsbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (queue_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
